// File: sv/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the pending request table
// Holds the item mode codes, the result status codes, the table entry layout
// and the request format of the shared compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

  // Mode of an input item.
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TAKE   = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  // Status of a result item.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  // Expiry limit after reset, in seconds.
  localparam logic [15:0] EXPIRY_RESET = 16'd60;

  // One stored table entry.
  typedef struct packed {
    logic        kind;
    logic [31:0] tag;
    logic [15:0] loc;
    logic [15:0] child;
    logic [31:0] stamp;
  } entry_t;

  // Operation of the shared compare unit.
  typedef enum logic {
    CMP_AGE = 1'b0,
    CMP_TAG = 1'b1
  } cmp_op_t;

  // Request to the shared compare unit.
  typedef struct packed {
    cmp_op_t     op;
    logic [31:0] now;
    logic [31:0] stamp;
    logic [15:0] expiry;
    logic [31:0] key;
    logic [31:0] tag;
  } cmp_req_t;

endpackage

`default_nettype wire

// File: sv/prt_cmp_unit.sv
// ----------------------------------------------------------------------------
// prt_cmp_unit: shared compare unit of the pending request table
// Either tests whether an entry has outlived the expiry limit (wrapping age
// greater than the limit) or whether its tag equals the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_cmp_unit (
  input  prt_pkg::cmp_req_t req,
  output logic              hit
);
  import prt_pkg::*;

  logic [31:0] age;

  // The age wraps as an unsigned 32-bit difference.
  assign age = req.now - req.stamp;

  always_comb begin
    unique case (req.op)
      CMP_AGE: hit = (age > {16'd0, req.expiry});
      CMP_TAG: hit = (req.key == req.tag);
      default: hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/pending_request_table.sv
// ----------------------------------------------------------------------------
// pending_request_table: table of outstanding requests with expiry
// Register items sweep expired entries and fill the lowest free slot; take and
// drop items free the lowest valid entry whose tag matches.
// ----------------------------------------------------------------------------
// Sequence: a register item reads and evaluates each slot in turn (S_READ,
// then S_EVAL) and then fills a slot or reports a full table in S_WRITE; a
// take or drop item reads and evaluates slots until one matches or the last
// is done. busy falls as the result strobe is shown, so the next item can be
// accepted while the strobe is high, but not before the last item is finished.
// Reset clears all valid bits and restores the expiry limit to 60 seconds.
`default_nettype none

module pending_request_table #(
  parameter int TABLE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_request_tag,
  input  wire logic [15:0] in_local_handle,
  input  wire logic [15:0] in_child_handle,
  input  wire logic [31:0] in_now_seconds,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_entry_kind,
  output logic [15:0]      out_entry_local_handle,
  output logic [15:0]      out_entry_child_handle,
  output logic [1:0]       out_slot_index,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import prt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WRITE
  } state_t;

  state_t                 state_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   found_r;
  logic [15:0]            expiry_r;

  // Captured input item.
  mode_t       mode_r;
  logic [31:0] tag_r;
  logic [15:0] loc_r;
  logic [15:0] child_r;
  logic [31:0] now_r;

  // Result registers.
  logic        out_valid_r;
  status_t     status_r;
  logic        kind_out_r;
  logic [15:0] loc_out_r;
  logic [15:0] child_out_r;
  logic [1:0]  slot_out_r;

  // Entry memory with registered read data.
  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;
  logic   wr_en;
  entry_t wr_entry;

  cmp_req_t cmp_req;
  logic     cmp_hit;
  logic     is_reg;
  logic     last;
  logic     cur_valid;
  logic [IDX_W+1:0] cnt_ext;
  logic [IDX_W+1:0] idx_ext;

  assign is_reg    = (mode_r == MODE_ADD) || (mode_r == MODE_REMOVE);
  assign last      = (cnt_r == LAST_IDX);
  assign cur_valid = valid_r[cnt_r];
  assign cnt_ext   = {2'b00, cnt_r};
  assign idx_ext   = {2'b00, idx_r};

  // Entry memory: one write port for fills, one read port for the scan.
  assign wr_en    = (state_r == S_WRITE) && found_r;
  assign wr_entry = '{kind:  (mode_r == MODE_REMOVE),
                      tag:   tag_r,
                      loc:   loc_r,
                      child: child_r,
                      stamp: now_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_entry;
    end
    rd_r <= mem[cnt_r];
  end

  // Shared compare unit: age test on register items, tag test otherwise.
  always_comb begin
    cmp_req.op     = is_reg ? CMP_AGE : CMP_TAG;
    cmp_req.now    = now_r;
    cmp_req.stamp  = rd_r.stamp;
    cmp_req.expiry = expiry_r;
    cmp_req.key    = tag_r;
    cmp_req.tag    = rd_r.tag;
  end

  prt_cmp_unit u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  // Sequencer: state, valid bits, expiry register and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      expiry_r    <= EXPIRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        expiry_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r  <= mode_t'(in_mode);
            tag_r   <= in_request_tag;
            loc_r   <= in_local_handle;
            child_r <= in_child_handle;
            now_r   <= in_now_seconds;
            cnt_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (is_reg) begin
            // Sweep this slot, then note it if it is the first free one.
            if (cur_valid && cmp_hit) begin
              valid_r[cnt_r] <= 1'b0;
            end
            if ((!cur_valid || cmp_hit) && !found_r) begin
              found_r <= 1'b1;
              idx_r   <= cnt_r;
            end
            if (last) begin
              state_r <= S_WRITE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_READ;
            end
          end else if (cur_valid && cmp_hit) begin
            // First matching entry: free it and report it.
            valid_r[cnt_r] <= 1'b0;
            out_valid_r    <= 1'b1;
            status_r       <= ST_OK;
            slot_out_r     <= cnt_ext[1:0];
            if (mode_r == MODE_TAKE) begin
              kind_out_r  <= rd_r.kind;
              loc_out_r   <= rd_r.loc;
              child_out_r <= rd_r.child;
            end else begin
              kind_out_r  <= 1'b0;
              loc_out_r   <= '0;
              child_out_r <= '0;
            end
            state_r <= S_IDLE;
          end else if (last) begin
            out_valid_r <= 1'b1;
            status_r    <= ST_NOMATCH;
            slot_out_r  <= '0;
            kind_out_r  <= 1'b0;
            loc_out_r   <= '0;
            child_out_r <= '0;
            state_r     <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_WRITE: begin
          // Fill the free slot found by the scan, or report a full table.
          out_valid_r <= 1'b1;
          kind_out_r  <= 1'b0;
          loc_out_r   <= '0;
          child_out_r <= '0;
          if (found_r) begin
            valid_r[idx_r] <= 1'b1;
            status_r       <= ST_OK;
            slot_out_r     <= idx_ext[1:0];
          end else begin
            status_r   <= ST_FULL;
            slot_out_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_entry_kind         = kind_out_r;
  assign out_entry_local_handle = loc_out_r;
  assign out_entry_child_handle = child_out_r;
  assign out_slot_index         = slot_out_r;

endmodule

`default_nettype wire

// File: sv/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker: port-level checks of the pending request table
// Watches the command and result ports over time and is bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic        out_entry_kind,
  input wire logic [15:0] out_entry_local_handle,
  input wire logic [15:0] out_entry_child_handle,
  input wire logic [1:0]  out_slot_index
);
  import prt_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result is only shown once the item is finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // The result strobe lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A failed item carries no slot and no entry contents.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOMATCH)) |->
      (out_slot_index == 2'd0 && !out_entry_kind &&
       out_entry_local_handle == 16'd0 && out_entry_child_handle == 16'd0))
    else $error("failed item returned slot or entry data");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_NOMATCH))
    else $error("undefined status code");

endmodule

bind pending_request_table prt_checker u_prt_checker (.*);

`default_nettype wire
